// ===== rtl/core/agc_pkg.sv =====
// ----------------------------------------------------------------------------
// agc_pkg
// Shared constants and controller/datapath interface types for the audio
// level tracker.
// ----------------------------------------------------------------------------
package agc_pkg;

    localparam int SAMPLE_BITS_DEF   = 10;
    localparam int FRACTION_BITS_DEF = 10;
    localparam int LEVEL_BITS_DEF    = 8;

    localparam int REG_W      = 10;
    localparam int CFG_ADDR_W = 1;

    localparam logic [REG_W-1:0] LEAK_STEP_RST      = REG_W'(1);
    localparam logic [REG_W-1:0] GATE_THRESHOLD_RST = REG_W'(3);

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_LEAK_STEP      = 1'b0,
        CFG_GATE_THRESHOLD = 1'b1
    } cfg_addr_t;

    typedef struct packed {
        logic load;
        logic eval;
        logic div_step;
        logic out_load;
    } agc_cmd_t;

    typedef struct packed {
        logic direct;
    } agc_status_t;

endpackage

// ===== rtl/core/agc_datapath.sv =====
// ----------------------------------------------------------------------------
// agc_datapath
// Running extremes, span and position, gate test, restoring divider and
// result register.
// ----------------------------------------------------------------------------
module agc_datapath import agc_pkg::*; #(
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    parameter int LEVEL_BITS    = LEVEL_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [REG_W-1:0]       cfg_wr_data,
    input  logic [SAMPLE_BITS-1:0] s_sample,
    input  agc_cmd_t               cmd,
    output agc_status_t            status,
    output logic [LEVEL_BITS-1:0]  m_level,
    output logic                   m_gate_closed
);

    localparam int STATE_W = SAMPLE_BITS + FRACTION_BITS + 2;
    localparam int NUM_W   = STATE_W - 1 + LEVEL_BITS;

    logic [REG_W-1:0]          leak_reg;
    logic [REG_W-1:0]          thr_reg;
    logic signed [STATE_W-1:0] min_reg;
    logic signed [STATE_W-1:0] max_reg;
    logic signed [STATE_W-1:0] x_reg;
    logic                      gate_reg;
    logic                      zero_reg;
    logic                      full_reg;
    logic [STATE_W-2:0]        span_reg;
    logic [STATE_W-2:0]        rem_reg;
    logic [LEVEL_BITS-1:0]     low_reg;
    logic [LEVEL_BITS-1:0]     quo_reg;
    logic [LEVEL_BITS-1:0]     level_reg;
    logic                      closed_reg;

    logic signed [STATE_W-1:0] x_next;
    logic signed [STATE_W-1:0] span_s;
    logic signed [STATE_W-1:0] above_s;
    logic signed [STATE_W-1:0] gate_s;
    logic signed [STATE_W-1:0] leak_s;
    logic [NUM_W-1:0]          num;
    logic                      is_gate;
    logic                      is_zero;
    logic                      is_full;
    logic [STATE_W-1:0]        trial;
    logic [STATE_W-1:0]        diff;
    logic [LEVEL_BITS-1:0]     level_next;

    always_comb begin
        x_next  = signed'(STATE_W'({s_sample, {FRACTION_BITS{1'b0}}}));
        span_s  = max_reg - min_reg;
        above_s = x_reg - min_reg;
        gate_s  = signed'(STATE_W'({thr_reg, {FRACTION_BITS{1'b0}}}));
        leak_s  = signed'(STATE_W'(leak_reg));
        num     = {above_s[STATE_W-2:0], {LEVEL_BITS{1'b0}}}
                  - NUM_W'(above_s[STATE_W-2:0]);
        is_gate = span_s < gate_s;
        is_zero = above_s[STATE_W-1] || (above_s == STATE_W'(0));
        is_full = above_s >= span_s;
        trial   = {rem_reg, low_reg[LEVEL_BITS-1]};
        diff    = trial - {1'b0, span_reg};
        if (gate_reg) begin
            level_next = '0;
        end else if (zero_reg) begin
            level_next = '0;
        end else if (full_reg) begin
            level_next = '1;
        end else begin
            level_next = quo_reg;
        end
    end

    assign status.direct = gate_reg || zero_reg || full_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            leak_reg <= LEAK_STEP_RST;
            thr_reg  <= GATE_THRESHOLD_RST;
            min_reg  <= '0;
            max_reg  <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_LEAK_STEP:      leak_reg <= cfg_wr_data;
                    CFG_GATE_THRESHOLD: thr_reg  <= cfg_wr_data;
                    default:            ;
                endcase
            end
            if (cmd.load) begin
                if (x_next < min_reg) begin
                    min_reg <= x_next;
                end
                if (x_next > max_reg) begin
                    max_reg <= x_next;
                end
            end else if (cmd.eval) begin
                min_reg <= min_reg + leak_s;
                max_reg <= max_reg - leak_s;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x_reg <= x_next;
        end
        if (cmd.eval) begin
            gate_reg <= is_gate;
            zero_reg <= !is_gate && is_zero;
            full_reg <= !is_gate && !is_zero && is_full;
            span_reg <= span_s[STATE_W-2:0];
            rem_reg  <= num[NUM_W-1:LEVEL_BITS];
            low_reg  <= num[LEVEL_BITS-1:0];
            quo_reg  <= '0;
        end else if (cmd.div_step) begin
            low_reg <= {low_reg[LEVEL_BITS-2:0], 1'b0};
            if (!diff[STATE_W-1] || trial >= {1'b0, span_reg}) begin
                if (trial >= {1'b0, span_reg}) begin
                    rem_reg <= diff[STATE_W-2:0];
                    quo_reg <= {quo_reg[LEVEL_BITS-2:0], 1'b1};
                end else begin
                    rem_reg <= trial[STATE_W-2:0];
                    quo_reg <= {quo_reg[LEVEL_BITS-2:0], 1'b0};
                end
            end else begin
                rem_reg <= trial[STATE_W-2:0];
                quo_reg <= {quo_reg[LEVEL_BITS-2:0], 1'b0};
            end
        end
        if (cmd.out_load) begin
            level_reg  <= level_next;
            closed_reg <= gate_reg;
        end
    end

    assign m_level       = level_reg;
    assign m_gate_closed = closed_reg;

endmodule

// ===== rtl/core/agc_ctrl.sv =====
// ----------------------------------------------------------------------------
// agc_ctrl
// Sequencer for one item: capture, evaluate, divide, hand over to the
// result register.
// ----------------------------------------------------------------------------
module agc_ctrl import agc_pkg::*; #(
    parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    output logic        m_valid,
    input  logic        m_ready,
    input  agc_status_t status,
    output agc_cmd_t    cmd
);

    localparam int CNT_W = $clog2(LEVEL_BITS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_FINISH
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               m_valid_reg;
    logic               out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        s_ready      = (state_reg == ST_IDLE);
        cmd.load     = (state_reg == ST_IDLE) && s_valid;
        cmd.eval     = (state_reg == ST_EVAL);
        cmd.div_step = (state_reg == ST_DIV) && !status.direct;
        cmd.out_load = (state_reg == ST_FINISH) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    cnt_reg   <= CNT_W'(LEVEL_BITS - 1);
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (status.direct || cnt_reg == '0) begin
                        state_reg <= ST_FINISH;
                    end else begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== rtl/core/audio_agc_level_tracker_top.sv =====
// ----------------------------------------------------------------------------
// audio_agc_level_tracker_top
// Peak-tracking level meter: running min/max with leak, gate on small span,
// level = (sample - min) * full scale / span.
//
//   channel   ports                                 direction
//   s_        s_valid s_ready s_sample              in
//   m_        m_valid m_ready m_level m_gate_closed out
//   cfg_      cfg_wr_en cfg_addr cfg_wr_data        in (write only)
//
// After acceptance an item passes ST_EVAL, ST_DIV and ST_FINISH, which loads
// the result; ST_DIV runs the divider (one restoring step a cycle) unless
// gated or clamped; the next item is accepted in the cycle after that load.
// Reset is synchronous, active low; extremes clear to zero, registers to
// their defaults. A waiting result holds in the output register; the next
// item is accepted meanwhile and stalls only at hand-over.
// ----------------------------------------------------------------------------
module audio_agc_level_tracker_top import agc_pkg::*; #(
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    parameter int LEVEL_BITS    = LEVEL_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [REG_W-1:0]       cfg_wr_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [SAMPLE_BITS-1:0] s_sample,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [LEVEL_BITS-1:0]  m_level,
    output logic                   m_gate_closed
);

    agc_cmd_t    cmd;
    agc_status_t status;

    agc_ctrl #(
        .LEVEL_BITS (LEVEL_BITS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    agc_datapath #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS),
        .LEVEL_BITS    (LEVEL_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wr_data   (cfg_wr_data),
        .s_sample      (s_sample),
        .cmd           (cmd),
        .status        (status),
        .m_level       (m_level),
        .m_gate_closed (m_gate_closed)
    );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the audio level tracker. A directed table walks the
// reset state, gate open and closed, zero span and both level rails, then
// phases of burst-shaped audio run under each register setting and each
// idling pattern. Checks use the typed rows or else a local peak tracker.
// ----------------------------------------------------------------------------
module testbench;
    import agc_pkg::*;

    localparam int SBITS          = SAMPLE_BITS_DEF;
    localparam int FBITS          = FRACTION_BITS_DEF;
    localparam int LBITS          = LEVEL_BITS_DEF;
    localparam longint FULL_SCALE = (longint'(1) << LBITS) - 1;
    localparam int SAMPLE_TOP     = (1 << SBITS) - 1;
    localparam int DRAIN_CYCLES   = 2 * (LBITS + 3);
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 230;
    localparam int SHOWN_ERRORS   = 10;

    typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;
    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
    typedef enum int {STYLE_TONE, STYLE_NOISE, STYLE_RAILS, STYLE_HOLD} burst_style_t;

    typedef struct packed {
        logic [LBITS-1:0] level;
        logic             gate;
    } level_res_t;

    typedef struct packed {
        row_kind_t        kind;
        logic [SBITS-1:0] sample;
        logic [REG_W-1:0] leak;
        logic [REG_W-1:0] thr;
        bit               typed;
        logic [LBITS-1:0] level;
        logic             gate;
    } dir_row_t;

    localparam int DIR_ROWS = 22;

    dir_row_t dir_rows [0:DIR_ROWS-1] = '{
        '{ROW_ITEM,   10'd0,    10'd0,    10'd0, 1'b1,   8'd0, 1'b1},
        '{ROW_CFG,    10'd0,    10'd1,    10'd0, 1'b0,   8'd0, 1'b0},
        '{ROW_ITEM,   10'd0,    10'd0,    10'd0, 1'b1,   8'd0, 1'b0},
        '{ROW_CFG,    10'd0,    10'd1,    10'd3, 1'b0,   8'd0, 1'b0},
        '{ROW_ITEM, 10'd1023,   10'd0,    10'd0, 1'b1, 8'd255, 1'b0},
        '{ROW_ITEM,   10'd0,    10'd0,    10'd0, 1'b1,   8'd0, 1'b0},
        '{ROW_ITEM, 10'd1023,   10'd0,    10'd0, 1'b1, 8'd255, 1'b0},
        '{ROW_ITEM,  10'd512,   10'd0,    10'd0, 1'b0,   8'd0, 1'b0},
        '{ROW_ITEM,  10'd341,   10'd0,    10'd0, 1'b0,   8'd0, 1'b0},
        '{ROW_ITEM,  10'd682,   10'd0,    10'd0, 1'b0,   8'd0, 1'b0},
        '{ROW_ITEM,    10'd1,   10'd0,    10'd0, 1'b0,   8'd0, 1'b0},
        '{ROW_ITEM, 10'd1022,   10'd0,    10'd0, 1'b0,   8'd0, 1'b0},
        '{ROW_CFG,    10'd0, 10'd1023, 10'd1023, 1'b0,   8'd0, 1'b0},
        '{ROW_ITEM,  10'd512,   10'd0,    10'd0, 1'b0,   8'd0, 1'b0},
        '{ROW_ITEM,    10'd0,   10'd0,    10'd0, 1'b0,   8'd0, 1'b0},
        '{ROW_ITEM, 10'd1023,   10'd0,    10'd0, 1'b0,   8'd0, 1'b0},
        '{ROW_ITEM,  10'd600,   10'd0,    10'd0, 1'b0,   8'd0, 1'b0},
        '{ROW_CFG,    10'd0,    10'd0,    10'd0, 1'b0,   8'd0, 1'b0},
        '{ROW_ITEM,  10'd300,   10'd0,    10'd0, 1'b0,   8'd0, 1'b0},
        '{ROW_ITEM,  10'd300,   10'd0,    10'd0, 1'b0,   8'd0, 1'b0},
        '{ROW_ITEM, 10'd1023,   10'd0,    10'd0, 1'b0,   8'd0, 1'b0},
        '{ROW_ITEM,    10'd0,   10'd0,    10'd0, 1'b0,   8'd0, 1'b0}
    };

    logic                  aclk;
    logic                  aresetn       = 1'b0;
    logic                  cfg_wr_en     = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr      = CFG_LEAK_STEP;
    logic [REG_W-1:0]      cfg_wr_data   = '0;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    logic [SBITS-1:0]      s_sample      = '0;
    logic                  m_valid;
    logic                  m_ready       = 1'b0;
    logic [LBITS-1:0]      m_level;
    logic                  m_gate_closed;

    level_res_t       pending_levels [$];
    longint           trk_min;
    longint           trk_max;
    logic [REG_W-1:0] leak_cfg;
    logic [REG_W-1:0] gate_cfg;
    idle_mode_t       idle_mode     = IDLE_NONE;
    int               errors        = 0;
    int               quiet_cycles  = 0;

    burst_style_t     burst_style   = STYLE_NOISE;
    int               burst_left    = 0;
    int               burst_center  = 0;
    int               burst_amp     = 0;

    audio_agc_level_tracker_top DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample      (s_sample),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_level       (m_level),
        .m_gate_closed (m_gate_closed)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic int sender_idle_pct();
        case (idle_mode)
            IDLE_SENDER: return 87;
            IDLE_BOTH:   return 18;
            default:     return 0;
        endcase
    endfunction

    function automatic int receiver_stall_pct();
        case (idle_mode)
            IDLE_RECEIVER: return 87;
            IDLE_BOTH:     return 18;
            default:       return 0;
        endcase
    endfunction

    function automatic level_res_t track_level(input logic [SBITS-1:0] sample);
        longint     x;
        longint     span;
        longint     above;
        longint     gate;
        level_res_t res;
        x     = longint'(sample) << FBITS;
        res   = '0;
        if (x < trk_min)
            trk_min = x;
        if (x > trk_max)
            trk_max = x;
        span  = trk_max - trk_min;
        above = x - trk_min;
        gate  = longint'(gate_cfg) << FBITS;
        if (span < gate) begin
            res.gate = 1'b1;
        end else if (above <= 0) begin
            res.level = '0;
        end else if (above >= span) begin
            res.level = FULL_SCALE[LBITS-1:0];
        end else begin
            res.level = LBITS'((above * FULL_SCALE) / span);
        end
        trk_min += longint'(leak_cfg);
        trk_max -= longint'(leak_cfg);
        return res;
    endfunction

    function automatic logic [SBITS-1:0] next_sample();
        int v;
        int pick;
        if (burst_left == 0) begin
            pick         = $urandom_range(99);
            burst_left   = $urandom_range(60, 10);
            burst_center = $urandom_range(SAMPLE_TOP);
            case ($urandom_range(2))
                0:       burst_amp = $urandom_range(8);
                1:       burst_amp = $urandom_range(100);
                default: burst_amp = $urandom_range(SAMPLE_TOP / 2);
            endcase
            if (pick < 55)
                burst_style = STYLE_TONE;
            else if (pick < 75)
                burst_style = STYLE_NOISE;
            else if (pick < 85)
                burst_style = STYLE_RAILS;
            else
                burst_style = STYLE_HOLD;
        end
        burst_left--;
        case (burst_style)
            STYLE_TONE: begin
                v = burst_center + int'($urandom_range(2 * burst_amp)) - burst_amp;
                if (v < 0)
                    v = 0;
                if (v > SAMPLE_TOP)
                    v = SAMPLE_TOP;
            end
            STYLE_RAILS: begin
                case ($urandom_range(3))
                    0:       v = 0;
                    1:       v = 1;
                    2:       v = SAMPLE_TOP - 1;
                    default: v = SAMPLE_TOP;
                endcase
            end
            STYLE_HOLD: v = burst_center;
            default:    v = $urandom_range(SAMPLE_TOP);
        endcase
        return SBITS'(v);
    endfunction

    task automatic note_mismatch(input string what, input level_res_t want,
                                 input level_res_t got);
        errors++;
        if (errors <= SHOWN_ERRORS)
            $display("%s: expected level %0d gate %0b, got level %0d gate %0b",
                     what, want.level, want.gate, got.level, got.gate);
    endtask

    task automatic send_item(input logic [SBITS-1:0] sample, input bit typed,
                             input level_res_t typed_res);
        level_res_t res;
        s_valid  <= 1'b1;
        s_sample <= sample;
        do
            @(posedge aclk);
        while (!s_ready);
        res = track_level(sample);
        pending_levels.push_back(typed ? typed_res : res);
    endtask

    task automatic pause_sender();
        while ($urandom_range(99) < sender_idle_pct()) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic drain_idle();
        s_valid <= 1'b0;
        while (pending_levels.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_regs(input logic [REG_W-1:0] leak, input logic [REG_W-1:0] thr);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= CFG_LEAK_STEP;
        cfg_wr_data <= leak;
        @(posedge aclk);
        leak_cfg     = leak;
        cfg_addr    <= CFG_GATE_THRESHOLD;
        cfg_wr_data <= thr;
        @(posedge aclk);
        gate_cfg     = thr;
        cfg_wr_en   <= 1'b0;
    endtask

    always @(posedge aclk) begin : result_check
        level_res_t want;
        level_res_t got;
        got = {m_level, m_gate_closed};
        if (aresetn && m_valid && m_ready) begin
            if (pending_levels.size() == 0) begin
                note_mismatch("unexpected item", '0, got);
            end else begin
                want = pending_levels.pop_front();
                if (want.level !== got.level || want.gate !== got.gate)
                    note_mismatch("mismatch", want, got);
            end
        end
        m_ready <= ($urandom_range(99) >= receiver_stall_pct());
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        trk_min  = 0;
        trk_max  = 0;
        leak_cfg = LEAK_STEP_RST;
        gate_cfg = GATE_THRESHOLD_RST;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                drain_idle();
                write_regs(dir_rows[i].leak, dir_rows[i].thr);
            end else begin
                send_item(dir_rows[i].sample, dir_rows[i].typed,
                          {dir_rows[i].level, dir_rows[i].gate});
                pause_sender();
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            drain_idle();
            idle_mode = idle_mode_t'(p % 4);
            case (p)
                1:       write_regs(10'd1023, 10'd1023);
                2:       write_regs(10'd0, 10'd0);
                4:       write_regs(10'd1023, 10'd0);
                5:       write_regs(10'd0, 10'd1023);
                7:       write_regs(LEAK_STEP_RST, GATE_THRESHOLD_RST);
                default: write_regs(REG_W'($urandom_range(1) ? $urandom_range(1023)
                                                              : $urandom_range(16)),
                                    REG_W'($urandom_range(1) ? $urandom_range(1023)
                                                              : $urandom_range(40)));
            endcase
            repeat (PHASE_ITEMS) begin
                send_item(next_sample(), 1'b0, '0);
                pause_sender();
            end
        end

        drain_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/agc_pkg.sv
rtl/core/agc_datapath.sv
rtl/core/agc_ctrl.sv
rtl/core/audio_agc_level_tracker_top.sv
tb/testbench.sv
